// ===== src/bbc_pkg.sv =====
// Shared types, codes and helpers for the BCD / binary converter.
// No dependencies; imported by every other file in src.
package bbc_pkg;

    // Operand and work-register width
    localparam int DataW        = 64;
    // Bits of operand consumed by one pipeline stage
    localparam int StepBits     = 8;
    // Number of conversion stages after the input register
    localparam int NumStages    = DataW / StepBits;
    // Decimal digits held in the work register
    localparam int NumDigits    = DataW / 4;

    typedef enum logic
    {
        OP_BCD_TO_BIN = 1'b0,
        OP_BIN_TO_BCD = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        WSEL_8  = 2'd0,
        WSEL_16 = 2'd1,
        WSEL_32 = 2'd2,
        WSEL_64 = 2'd3
    } wsel_t;

    // Word carried between conversion stages
    typedef struct packed
    {
        op_t              op;
        wsel_t            wsel;
        logic [DataW-1:0] work;   // operand, consumed from the top
        logic [DataW-1:0] acc;    // binary sum or BCD digits so far
    } stage_word_t;

    // Keep only the bits of the selected width
    function automatic logic [DataW-1:0] width_mask(input wsel_t wsel);
        logic [DataW-1:0] m;
        case (wsel)
            WSEL_8:  m = {{(DataW-8){1'b0}},  {8{1'b1}}};
            WSEL_16: m = {{(DataW-16){1'b0}}, {16{1'b1}}};
            WSEL_32: m = {{(DataW-32){1'b0}}, {32{1'b1}}};
            default: m = {DataW{1'b1}};
        endcase
        return m;
    endfunction

endpackage

// ===== src/bbc_stage.sv =====
// One conversion stage: eight double-dabble steps or one two-digit Horner step.
// Depends on bbc_pkg.
module bbc_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  bbc_pkg::stage_word_t in_word,
    output logic                 out_valid,
    output bbc_pkg::stage_word_t out_word
);
    import bbc_pkg::*;

    logic        valid_reg;
    stage_word_t word_reg;
    stage_word_t word_next;

    // Conversion work for this stage
    always_comb
    begin
        logic [DataW-1:0] work;
        logic [DataW-1:0] acc;
        logic [3:0]       hi;
        logic [3:0]       lo;
        logic [7:0]       pair;
        work = in_word.work;
        acc  = in_word.acc;
        hi   = work[DataW-1 -: 4];
        lo   = work[DataW-5 -: 4];
        pair = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
        if (in_word.op == OP_BIN_TO_BCD)
        begin
            // shift-add-3; digits above the top one are dropped
            for (int s = 0; s < StepBits; s++)
            begin
                for (int d = 0; d < NumDigits; d++)
                begin
                    if (acc[4*d +: 4] >= 4'd5)
                    begin
                        acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                    end
                end
                acc  = {acc[DataW-2:0], work[DataW-1]};
                work = {work[DataW-2:0], 1'b0};
            end
        end
        else
        begin
            // acc * 100 + next two digits, nibbles weighted as they stand
            acc  = (acc << 6) + (acc << 5) + (acc << 2) + {{(DataW-8){1'b0}}, pair};
            work = {work[DataW-StepBits-1:0], {StepBits{1'b0}}};
        end
        word_next      = in_word;
        word_next.work = work;
        word_next.acc  = acc;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== src/bbc_out_buf.sv =====
// Output register with one skid entry; stalls the pipeline only when the skid fills.
// Depends on bbc_pkg.
module bbc_out_buf
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bbc_pkg::DataW-1:0] in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bbc_pkg::DataW-1:0] out_data
);
    import bbc_pkg::*;

    logic             main_valid_reg;
    logic             skid_valid_reg;
    logic [DataW-1:0] main_reg;
    logic [DataW-1:0] skid_reg;
    logic             push;
    logic             pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && !skid_valid_reg;
    assign pop      = main_valid_reg && out_ready;

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= in_data;
            end
            else
            begin
                main_reg <= in_data;
            end
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== src/bcd_binary_converter.sv =====
// Top level of the BCD / binary converter: input register, conversion stages, output buffer.
// Depends on bbc_pkg, bbc_stage and bbc_out_buf.
//
//  channel  | dir | tdata              | tuser
//  s_axis   | in  | value_in[63:0]     | operation[0], width_select[2:1]
//  m_axis   | out | value_out[63:0]    | -
//
// From acceptance to m_axis_tvalid a word passes one input register, eight conversion
// stages (eight binary bits or two BCD digits each), one output register. One word is
// accepted per cycle while the skid entry is free; the per-stage double-dabble and x100
// add set the cycle. Reset clears only valid bits. A stall on m_axis fills the skid entry,
// which then freezes the whole pipeline; s_axis_tready is registered and nothing is dropped.
module bcd_binary_converter
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [bbc_pkg::DataW-1:0] s_axis_tdata,   // value_in[63:0]
    input  logic [2:0]                s_axis_tuser,   // operation[0], width_select[2:1]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [bbc_pkg::DataW-1:0] m_axis_tdata    // value_out[63:0]
);
    import bbc_pkg::*;

    logic        en;
    logic        buf_ready;
    logic        align_valid_reg;
    stage_word_t align_reg;
    stage_word_t align_next;
    logic        stg_valid [NumStages+1];
    stage_word_t stg_word  [NumStages+1];
    logic [DataW-1:0] result;

    // Pipeline advances while the skid entry is free
    assign en            = buf_ready;
    assign s_axis_tready = en;

    // Operand register; bits above the selected width are cleared so the
    // leading stages only see zeros
    always_comb
    begin
        align_next.op   = op_t'(s_axis_tuser[0]);
        align_next.wsel = wsel_t'(s_axis_tuser[2:1]);
        align_next.work = s_axis_tdata & width_mask(wsel_t'(s_axis_tuser[2:1]));
        align_next.acc  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            align_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            align_reg <= align_next;
        end
    end

    assign stg_valid[0] = align_valid_reg;
    assign stg_word[0]  = align_reg;

    // Conversion stages
    for (genvar i = 0; i < NumStages; i++)
    begin : g_stage
        bbc_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[i]),
            .in_word   (stg_word[i]),
            .out_valid (stg_valid[i+1]),
            .out_word  (stg_word[i+1])
        );
    end

    // Drop digits / bits beyond the selected width
    assign result = stg_word[NumStages].acc & width_mask(stg_word[NumStages].wsel);

    bbc_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[NumStages]),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
